FILE: rtl/cctm_pkg.sv
// Shared widths, codes and control types for the cycle-count microsecond timebase.
package cctm_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int SUM_WIDTH  = WORD_WIDTH + 1;
	localparam int ACC_WIDTH  = 64;
	localparam int CPM_WIDTH  = 10;

	localparam logic [CPM_WIDTH-1:0] CPM_RESET = CPM_WIDTH'(180);

	typedef enum logic {
		ACTION_SAMPLE = 1'b0,
		ACTION_START  = 1'b1
	} action_t;

	// Command from the sequencer to the divider.
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	// Status from the divider back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/cctm_if.sv
// Valid/ready channel interfaces for sample items and microsecond results.
interface cctm_sample_if
	import cctm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [WORD_WIDTH-1:0] cycle_count;
	logic [WORD_WIDTH-1:0] seed_microseconds;

	modport source (output valid, output action, output cycle_count,
		output seed_microseconds, input ready);
	modport sink (input valid, input action, input cycle_count,
		input seed_microseconds, output ready);
endinterface

interface cctm_time_if
	import cctm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [WORD_WIDTH-1:0] microseconds;

	modport source (output valid, output microseconds, input ready);
	modport sink (input valid, input microseconds, output ready);
endinterface

FILE: rtl/cctm_divider.sv
// Bit-serial restoring divider: 33-bit dividend by 10-bit divisor, one quotient bit a cycle.
module cctm_divider
	import cctm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_ctrl_t            ctrl,
	input  logic [SUM_WIDTH-1:0] dividend,
	input  logic [CPM_WIDTH-1:0] divisor,
	output div_stat_t            stat,
	output logic [SUM_WIDTH-1:0] quotient,
	output logic [CPM_WIDTH-1:0] remainder
);

	localparam int CNT_WIDTH = $clog2(SUM_WIDTH + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic [SUM_WIDTH-1:0] dvd_q;
	logic [CPM_WIDTH-1:0] rem_q;
	logic [CPM_WIDTH-1:0] dvs_q;

	logic [CPM_WIDTH:0]   trial;
	logic                 ge;
	logic [CPM_WIDTH:0]   diff;

	// Shift in the next dividend bit and try one subtraction
	always_comb begin
		trial = {rem_q, dvd_q[SUM_WIDTH-1]};
		ge    = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	// Control: count iterations, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_WIDTH'(SUM_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_WIDTH'(1);
				if (cnt_q == CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend and quotient share the shift register
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_WIDTH-2:0], ge};
			rem_q <= ge ? diff[CPM_WIDTH-1:0] : trial[CPM_WIDTH-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/cycle_count_to_microsecond_timebase.sv
// Top level: converts cycle-counter samples into a running microsecond time.
//
// Channels: sample_ch (sink) carries action, cycle_count and seed_microseconds;
// time_ch (source) returns one microseconds result per item. cfg_wr_en with
// cfg_wr_data writes cycles_per_microsecond (0 acts as 1); write it only idle.
// A start item seeds the time and returns the seed in the cycle after accept;
// a sample before any start returns zero. A running sample
// adds the wrapped cycle delta to the leftover cycles and divides by
// cycles_per_microsecond in a bit-serial restoring divider, one quotient bit
// per cycle over 33 bits, then adds the quotient to a 64-bit accumulator.
// A sample goes through ST_DIV while the divider loop runs, then ST_FINISH, where
// the result is loaded; the next item is accepted only back in ST_IDLE. Start
// items and samples before start are answered straight from ST_IDLE.
// The input is not ready while a division runs, or while the output register
// is full and the receiver stalls; a held result stays until taken.
// Reset clears the time state, the output register and loads the divisor 180.
module cycle_count_to_microsecond_timebase
	import cctm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	cctm_sample_if.sink          sample_ch,
	cctm_time_if.source          time_ch,
	input  logic                 cfg_wr_en,
	input  logic [CPM_WIDTH-1:0] cfg_wr_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                 state_q;
	logic [CPM_WIDTH-1:0]   cpm_q;
	logic                   started_q;
	logic [WORD_WIDTH-1:0]  last_q;
	logic [CPM_WIDTH-1:0]   leftover_q;
	logic [ACC_WIDTH-1:0]   acc_q;
	logic                   out_valid_q;
	logic [WORD_WIDTH-1:0]  out_data_q;

	logic                   accept;
	logic                   out_free;
	logic                   out_load;
	logic [WORD_WIDTH-1:0]  delta;
	logic [SUM_WIDTH-1:0]   sum;
	logic [CPM_WIDTH-1:0]   divisor;
	logic [ACC_WIDTH-1:0]   acc_next;
	div_ctrl_t              div_ctrl;
	div_stat_t              div_stat;
	logic [SUM_WIDTH-1:0]   quotient;
	logic [CPM_WIDTH-1:0]   remainder;

	assign out_free        = !out_valid_q || time_ch.ready;
	assign sample_ch.ready = (state_q == ST_IDLE) && out_free;
	assign accept          = sample_ch.valid && sample_ch.ready;

	// Load the output register on an immediate result or a finished division
	assign out_load = ((state_q == ST_IDLE) && accept
			&& ((sample_ch.action == ACTION_START) || !started_q))
		|| ((state_q == ST_FINISH) && out_free);

	// Form the dividend and the effective divisor
	always_comb begin
		delta    = sample_ch.cycle_count - last_q;
		sum      = {1'b0, delta} + SUM_WIDTH'(leftover_q);
		divisor  = (cpm_q == '0) ? CPM_WIDTH'(1) : cpm_q;
		acc_next = acc_q + ACC_WIDTH'(quotient);
	end

	assign div_ctrl.start = accept && started_q
		&& (sample_ch.action == ACTION_SAMPLE);

	cctm_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (sum),
		.divisor   (divisor),
		.stat      (div_stat),
		.quotient  (quotient),
		.remainder (remainder)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q <= CPM_RESET;
		end else if (cfg_wr_en) begin
			cpm_q <= cfg_wr_data;
		end
	end

	// Sequencer, time state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			last_q      <= '0;
			leftover_q  <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (time_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sample_ch.action == ACTION_START) begin
							started_q   <= 1'b1;
							last_q      <= sample_ch.cycle_count;
							leftover_q  <= '0;
							acc_q       <= ACC_WIDTH'(sample_ch.seed_microseconds);
							out_data_q  <= sample_ch.seed_microseconds;
						end else if (!started_q) begin
							out_data_q  <= '0;
						end else begin
							last_q  <= sample_ch.cycle_count;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Hold the result until the output register is free
					if (out_free) begin
						acc_q       <= acc_next;
						leftover_q  <= remainder;
						out_data_q  <= acc_next[WORD_WIDTH-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign time_ch.valid        = out_valid_q;
	assign time_ch.microseconds = out_data_q;

endmodule

FILE: tb/cctm_timebase_checker.sv
`timescale 1ns / 1ps
// Checker for the microsecond timebase: predicts each result and compares it.
module cctm_timebase_checker
	import cctm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  in_action,
	input  logic [WORD_WIDTH-1:0] in_cycle_count,
	input  logic [WORD_WIDTH-1:0] in_seed,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [WORD_WIDTH-1:0] out_microseconds,
	input  logic                  cfg_wr_en,
	input  logic [CPM_WIDTH-1:0]  cfg_wr_data,
	output int                    fail_count,
	output int                    pending
);

	// Shadow of the block's time state and divisor
	logic [CPM_WIDTH-1:0]  divisor;
	logic                  running;
	logic [WORD_WIDTH-1:0] prev_count;
	logic [CPM_WIDTH-1:0]  leftover;
	logic [ACC_WIDTH-1:0]  total_us;
	logic [WORD_WIDTH-1:0] want_us;
	logic [WORD_WIDTH-1:0] expected_us_q[$];

	// Advance the shadow time by one item and return the microseconds it reports
	function automatic logic [WORD_WIDTH-1:0] advance_microseconds(
		input action_t               act,
		input logic [WORD_WIDTH-1:0] now,
		input logic [WORD_WIDTH-1:0] seed
	);
		logic [WORD_WIDTH-1:0] delta;
		logic [SUM_WIDTH-1:0]  span;
		logic [SUM_WIDTH-1:0]  div;
		logic [SUM_WIDTH-1:0]  quot;
		if (act == ACTION_START) begin
			running    = 1'b1;
			prev_count = now;
			leftover   = '0;
			total_us   = ACC_WIDTH'(seed);
			return seed;
		end
		// a sample before any start reports zero and leaves the state alone
		if (!running)
			return '0;
		delta = now - prev_count;
		span  = SUM_WIDTH'(delta) + SUM_WIDTH'(leftover);
		// a zero divisor behaves as one
		div   = (divisor == '0) ? SUM_WIDTH'(1) : SUM_WIDTH'(divisor);
		quot  = span / div;
		leftover   = CPM_WIDTH'(span % div);
		prev_count = now;
		total_us   = total_us + ACC_WIDTH'(quot);
		return total_us[WORD_WIDTH-1:0];
	endfunction

	// Track config writes, queue predictions, check results in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor    = CPM_RESET;
			running    = 1'b0;
			prev_count = '0;
			leftover   = '0;
			total_us   = '0;
			expected_us_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_wr_en)
				divisor = cfg_wr_data;
			if (in_valid && in_ready)
				expected_us_q.push_back(advance_microseconds(action_t'(in_action),
					in_cycle_count, in_seed));
			if (out_valid && out_ready) begin
				if (expected_us_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual microseconds %h",
						$time, out_microseconds);
					fail_count++;
				end else begin
					want_us = expected_us_q.pop_front();
					if (out_microseconds !== want_us) begin
						$display("%0t: microseconds expected %h actual %h",
							$time, want_us, out_microseconds);
						fail_count++;
					end
				end
			end
			pending = expected_us_q.size();
		end
	end

endmodule

FILE: tb/cycle_count_to_microsecond_timebase_tb.sv
`timescale 1ns / 1ps
// Testbench top for the microsecond timebase: clock, reset, stimulus and verdict.
module cycle_count_to_microsecond_timebase_tb;
	import cctm_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CPM_WIDTH-1:0]  cfg_wr_data;
	bit                    calm;
	bit                    hold_req;
	int                    fail_count;
	int                    pending;
	logic [WORD_WIDTH-1:0] count_now;

	cctm_sample_if sample_ch();
	cctm_time_if   time_ch();

	cycle_count_to_microsecond_timebase u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_ch   (sample_ch),
		.time_ch     (time_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	cctm_timebase_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (sample_ch.valid),
		.in_ready         (sample_ch.ready),
		.in_action        (sample_ch.action),
		.in_cycle_count   (sample_ch.cycle_count),
		.in_seed          (sample_ch.seed_microseconds),
		.out_valid        (time_ch.valid),
		.out_ready        (time_ch.ready),
		.out_microseconds (time_ch.microseconds),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.fail_count       (fail_count),
		.pending          (pending)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one item, with an optional idle burst first; return at its accept edge
	task automatic send_item(
		input action_t               act,
		input logic [WORD_WIDTH-1:0] cnt,
		input logic [WORD_WIDTH-1:0] seed
	);
		if (!calm && $urandom_range(0, 2) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		sample_ch.valid             <= 1'b1;
		sample_ch.action            <= act;
		sample_ch.cycle_count       <= cnt;
		sample_ch.seed_microseconds <= seed;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// Wait until every predicted result has been taken
	task automatic drain_results();
		do @(negedge clk); while (pending != 0);
	endtask

	// Write the divisor once the block has gone idle
	task automatic set_divisor(input logic [CPM_WIDTH-1:0] value);
		drain_results();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Mostly advancing samples with random spans, some restarts and some wild counts
	task automatic run_phase(
		input logic [CPM_WIDTH-1:0] div,
		input int                   n_items,
		input bit                   quiet,
		input bit                   squeeze
	);
		int kind;
		set_divisor(div);
		calm = quiet;
		for (int i = 0; i < n_items; i++) begin
			if (squeeze && i == 20)
				hold_req = 1'b1;
			kind = $urandom_range(0, 99);
			if (kind < 5) begin
				count_now = $urandom;
				send_item(ACTION_START, count_now, $urandom);
			end else if (kind < 10) begin
				count_now = $urandom;
				send_item(ACTION_SAMPLE, count_now, $urandom);
			end else begin
				case ($urandom_range(0, 3))
					0: count_now = count_now + $urandom_range(0, 3000);
					1: count_now = count_now + $urandom_range(0, 1 << 20);
					2: count_now = count_now + $urandom;
					default: count_now = count_now + 32'(div) * $urandom_range(0, 4);
				endcase
				send_item(ACTION_SAMPLE, count_now, $urandom);
			end
		end
		sample_ch.valid <= 1'b0;
	endtask

	// Result side: random stall bursts, one long hold-off on request
	initial begin
		time_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				time_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				time_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				time_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Stimulus
	initial begin
		arst_n                      <= 1'b0;
		cfg_wr_en                   <= 1'b0;
		cfg_wr_data                 <= CPM_RESET;
		sample_ch.valid             <= 1'b0;
		sample_ch.action            <= ACTION_SAMPLE;
		sample_ch.cycle_count       <= '0;
		sample_ch.seed_microseconds <= '0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		count_now = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// samples before any start, then wrap, big span, zero span, reseed
		send_item(ACTION_SAMPLE, '1, '1);
		send_item(ACTION_SAMPLE, '0, '0);
		send_item(ACTION_START, 32'hFFFF_FFF0, '1);
		send_item(ACTION_SAMPLE, 32'h0000_0010, '0);
		send_item(ACTION_SAMPLE, 32'h8000_000F, 32'h5555_5555);
		send_item(ACTION_SAMPLE, 32'h8000_000F, '0);
		send_item(ACTION_START, '0, '0);
		send_item(ACTION_SAMPLE, '1, '0);
		send_item(ACTION_START, 32'h1234_5678, 32'h8000_0000);
		send_item(ACTION_SAMPLE, 32'h1234_5678 + 32'd179, '0);
		send_item(ACTION_SAMPLE, 32'h1234_5678 + 32'd180, '0);
		sample_ch.valid <= 1'b0;

		// build a large leftover, then shrink the divisor under it
		set_divisor(CPM_WIDTH'(1000));
		send_item(ACTION_START, '0, 32'hAAAA_AAAA);
		send_item(ACTION_SAMPLE, 32'd999, '0);
		sample_ch.valid <= 1'b0;
		set_divisor(CPM_WIDTH'(1));
		// full span plus leftover gives a 33-bit quotient
		send_item(ACTION_SAMPLE, 32'd998, '0);
		sample_ch.valid <= 1'b0;
		set_divisor('0);
		send_item(ACTION_SAMPLE, 32'd998 + 32'd5000, '0);
		sample_ch.valid <= 1'b0;
		set_divisor('1);
		send_item(ACTION_SAMPLE, 32'd5997, '0);
		send_item(ACTION_SAMPLE, 32'd5997 + 32'd1023, '0);
		sample_ch.valid <= 1'b0;
		count_now = 32'd5997 + 32'd1023;

		// random phases over several divisors; the last one runs without idling
		run_phase(CPM_RESET, 150, 1'b0, 1'b0);
		run_phase(CPM_WIDTH'(1000), 150, 1'b0, 1'b1);
		run_phase(CPM_WIDTH'(1), 150, 1'b1, 1'b0);
		run_phase('0, 100, 1'b0, 1'b0);
		run_phase('1, 150, 1'b0, 1'b0);
		run_phase(CPM_WIDTH'($urandom_range(2, 999)), 150, 1'b0, 1'b0);
		run_phase(CPM_WIDTH'(37), 150, 1'b0, 1'b0);
		run_phase(CPM_RESET, 150, 1'b1, 1'b0);

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#(10_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cctm_pkg.sv
rtl/cctm_if.sv
rtl/cctm_divider.sv
rtl/cycle_count_to_microsecond_timebase.sv
tb/cctm_timebase_checker.sv
tb/cycle_count_to_microsecond_timebase_tb.sv
